[src/rvt_pkg.sv]
`default_nettype none

package rvt_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int PHASE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;

    localparam int STEP_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 32;
    localparam int GUARD_BITS  = 16;
    localparam int PRE_WIDTH   = COORD_WIDTH + 1;
    localparam int GAIN_WIDTH  = 33;
    localparam int PROD_WIDTH  = PRE_WIDTH + GAIN_WIDTH;
    localparam int DATA_WIDTH  = COORD_WIDTH + GUARD_BITS + 2;
    localparam int Z_WIDTH     = ANGLE_WIDTH + 2;
    localparam int CNT_WIDTH   = $clog2(ROTATION_STAGES);
    localparam int ATAN_IDX_W  = 5;

    localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(104);

    // Inverse of the CORDIC gain as an unsigned fraction of 2^32, kept positive in 33 bits.
    localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q32 = GAIN_WIDTH'(64'd2608131496);

    localparam logic signed [DATA_WIDTH-1:0] ROUND_HALF = DATA_WIDTH'(1) << (GUARD_BITS - 1);
    localparam logic signed [DATA_WIDTH-1:0] COORD_MAX  =
        (DATA_WIDTH'(1) << (COORD_WIDTH - 1)) - DATA_WIDTH'(1);
    localparam logic signed [DATA_WIDTH-1:0] COORD_MIN  = -COORD_MAX - DATA_WIDTH'(1);

    localparam logic [CNT_WIDTH-1:0] LAST_STAGE = CNT_WIDTH'(ROTATION_STAGES - 1);

    typedef struct packed {
        logic signed [PRE_WIDTH-1:0] x;
        logic signed [PRE_WIDTH-1:0] y;
        logic signed [Z_WIDTH-1:0]   z;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // atan(2^-k) in units of a full turn over 2^32, rounded to nearest.
    function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] k);
        logic [ANGLE_WIDTH-1:0] a;
        case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[src/rvt_ifs.sv]
`default_nettype none

interface rvt_in_if;
    import rvt_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic                          frame_start;

    modport source (output valid, output x_in, output y_in, output frame_start, input ready);
    modport sink   (input valid, input x_in, input y_in, input frame_start, output ready);
endinterface

interface rvt_out_if;
    import rvt_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic                          clipped;

    modport source (output valid, output x_out, output y_out, output clipped, input ready);
    modport sink   (input valid, input x_out, input y_out, input clipped, output ready);
endinterface

`default_nettype wire

[src/rvt_front.sv]
`default_nettype none

module rvt_front import rvt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [STEP_WIDTH-1:0] i_cfg_wr_data,
    rvt_in_if.sink                     i_vtx,
    input  wire logic                  i_full,
    output t_slot                      o_push
);

    logic [PHASE_WIDTH-1:0] r_phase;
    logic [STEP_WIDTH-1:0]  r_step;
    logic [PHASE_WIDTH-1:0] n_phase;
    logic [ANGLE_WIDTH-1:0] angle;
    logic [ANGLE_WIDTH-1:0] resid;
    logic                   fold;
    logic                   accept;
    logic signed [PRE_WIDTH-1:0] x_ext;
    logic signed [PRE_WIDTH-1:0] y_ext;

    assign i_vtx.ready = !i_full;
    assign accept      = i_vtx.valid && !i_full;

    always_comb begin
        n_phase = i_vtx.frame_start ? (r_phase + PHASE_WIDTH'(r_step)) : r_phase;
        angle   = ANGLE_WIDTH'(64'(n_phase) << (ANGLE_WIDTH - PHASE_WIDTH));
        // Angles in the left half-plane are mirrored by a half turn so the
        // residual stays within the quarter turn the micro-rotations cover.
        fold    = angle[ANGLE_WIDTH-1] ^ angle[ANGLE_WIDTH-2];
        resid   = fold ? {~angle[ANGLE_WIDTH-1], angle[ANGLE_WIDTH-2:0]} : angle;
        x_ext   = PRE_WIDTH'(i_vtx.x_in);
        y_ext   = PRE_WIDTH'(i_vtx.y_in);

        o_push.valid   = accept;
        o_push.entry.x = fold ? -x_ext : x_ext;
        o_push.entry.y = fold ? -y_ext : y_ext;
        o_push.entry.z = Z_WIDTH'($signed(resid));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= STEP_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

`default_nettype wire

[src/rvt_queue.sv]
`default_nettype none

module rvt_queue import rvt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_slot i_push,
    output logic       o_full,
    output t_slot      o_head,
    input  wire logic  i_pop
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full       = (r_count == 2'd2);
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

`default_nettype wire

[src/rvt_back.sv]
`default_nettype none

module rvt_back import rvt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_slot i_head,
    output logic       o_pop,
    rvt_out_if.source  o_vtx
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GAIN = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                    r_state,   n_state;
    logic [CNT_WIDTH-1:0]          r_cnt,     n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic signed [PROD_WIDTH-1:0]  r_px,      n_px;
    logic signed [PROD_WIDTH-1:0]  r_py,      n_py;
    logic signed [DATA_WIDTH-1:0]  r_x,       n_x;
    logic signed [DATA_WIDTH-1:0]  r_y,       n_y;
    logic signed [Z_WIDTH-1:0]     r_z,       n_z;
    logic signed [COORD_WIDTH-1:0] r_x_out,   n_x_out;
    logic signed [COORD_WIDTH-1:0] r_y_out,   n_y_out;
    logic                          r_clipped, n_clipped;

    logic signed [DATA_WIDTH-1:0]  dx, dy;
    logic signed [Z_WIDTH-1:0]     da;
    logic signed [DATA_WIDTH-1:0]  x_rnd, y_rnd;
    logic signed [DATA_WIDTH-1:0]  x_sat, y_sat;
    logic                          x_hit, y_hit;
    logic                          out_free;

    assign o_vtx.valid   = r_out_valid;
    assign o_vtx.x_out   = r_x_out;
    assign o_vtx.y_out   = r_y_out;
    assign o_vtx.clipped = r_clipped;

    assign out_free = !r_out_valid || o_vtx.ready;

    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        da = Z_WIDTH'(atan_turn(ATAN_IDX_W'(r_cnt)));

        x_rnd = (r_x + ROUND_HALF) >>> GUARD_BITS;
        y_rnd = (r_y + ROUND_HALF) >>> GUARD_BITS;
        x_hit = (x_rnd > COORD_MAX) || (x_rnd < COORD_MIN);
        y_hit = (y_rnd > COORD_MAX) || (y_rnd < COORD_MIN);
        x_sat = (x_rnd > COORD_MAX) ? COORD_MAX : ((x_rnd < COORD_MIN) ? COORD_MIN : x_rnd);
        y_sat = (y_rnd > COORD_MAX) ? COORD_MAX : ((y_rnd < COORD_MIN) ? COORD_MIN : y_rnd);

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_vtx.ready;
        n_px        = r_px;
        n_py        = r_py;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_x_out     = r_x_out;
        n_y_out     = r_y_out;
        n_clipped   = r_clipped;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_px    = PROD_WIDTH'(i_head.entry.x) * PROD_WIDTH'(GAIN_Q32);
                    n_py    = PROD_WIDTH'(i_head.entry.y) * PROD_WIDTH'(GAIN_Q32);
                    n_z     = i_head.entry.z;
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                n_x     = DATA_WIDTH'(r_px >>> (ANGLE_WIDTH - GUARD_BITS));
                n_y     = DATA_WIDTH'(r_py >>> (ANGLE_WIDTH - GUARD_BITS));
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                // One micro-rotation per cycle, direction set by the sign of the residual.
                if (!r_z[Z_WIDTH-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - da;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + da;
                end
                if (r_cnt == LAST_STAGE) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_WIDTH'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_x_out     = COORD_WIDTH'(x_sat);
                    n_y_out     = COORD_WIDTH'(y_sat);
                    n_clipped   = x_hit || y_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_py      <= n_py;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_x_out   <= n_x_out;
        r_y_out   <= n_y_out;
        r_clipped <= n_clipped;
    end

endmodule

`default_nettype wire

[src/rotating_vertex_transform.sv]
// Channel   Direction  Handshake       Payload
// i_vtx     in         valid / ready   x_in, y_in, frame_start
// o_vtx     out        valid / ready   x_out, y_out, clipped
// i_cfg_*   in         write enable    phase_step (16 bits)
//
// The front end takes one vertex per clock until its two-entry queue is full.
// Each vertex then passes through the back end in order: a gain multiply, a load,
// one micro-rotation per cycle through the shared shift-add unit for each of the
// ROTATION_STAGES stages, and a rounding step into the output register.
// Reset clears the phase to zero and sets phase_step to 104.
// A stalled result holds in the output register while the next vertex is computed.
`default_nettype none

module rotating_vertex_transform import rvt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [STEP_WIDTH-1:0] i_cfg_wr_data,
    rvt_in_if.sink                     i_vtx,
    rvt_out_if.source                  o_vtx
);

    t_slot push;
    t_slot head;
    logic  full;
    logic  pop;

    rvt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_vtx         (i_vtx),
        .i_full        (full),
        .o_push        (push)
    );

    rvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    rvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_vtx   (o_vtx)
    );

endmodule

`default_nettype wire
